// ===== rtl/tem_pkg.sv =====
`default_nettype none

package tem_pkg;

    // Item commands
    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_END    = 2'd2,
        CMD_IGNORE = 2'd3
    } t_command;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCALE_X = 2'd0;
    localparam logic [1:0] CFG_SCALE_Y = 2'd1;
    localparam logic [1:0] CFG_STOP    = 2'd2;

    // Reset values of the configuration registers
    localparam logic signed [15:0] SCALE_RESET = 16'sd256;

    // Special characters
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_PCT  = 8'h25;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_NL   = 8'h0A;

    // Escape holding buffer
    localparam int         HELD_MAX     = 10;
    localparam logic [3:0] ESC_LEAD_LEN = 4'd2;   // backslash plus kind byte
    localparam logic [3:0] NEED_HASH    = 4'd8;
    localparam logic [3:0] NEED_PCT     = 4'd10;

    // Controller to datapath
    typedef struct packed {
        logic in_load;      // capture an input beat
        logic tbl_write;    // write the width table
        logic sel_held;     // glyph lookup from the held buffer
        logic glyph_mul;    // width times scale_x
        logic glyph_acc;    // add product into pen x
        logic newline;      // end the line
        logic set_stop;     // stop mode newline
        logic push;         // hold the current byte
        logic flush_start;
        logic flush_next;
        logic flush_end;
        logic out_load;     // load result and clear the measurement
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_command command;
        logic     is_nl;
        logic     is_bsl;
        logic     is_lead;      // '#' or '%'
        logic     is_hex;
        logic     held_zero;
        logic     held_one;
        logic     held_mid;     // kind seen, room for more digits
        logic     stopped;
        logic     stop_mode;
        logic     flush_last;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/text_extent_measure_core.sv =====
// Table load, ignored command, newline and escape bytes finish in decode; an
//   ordinary glyph goes through decode (with the registered table read), multiply
//   and accumulate. A failed escape replays each held byte (at most 9) through table
//   read, multiply and accumulate, then rescans. End of string flushes held bytes,
//   then loads its result once the output register is free. A new item is accepted only in idle.
// Reset: synchronous, active low; clears the measurement, restores the scales to 1.0;
//   the width table is not cleared and is undefined until written.
`default_nettype none

module text_extent_measure_core #(
    parameter int GLYPH_COUNT = 224,
    parameter int FIRST_CODE  = 32
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    // configuration
    input  wire                i_cfg_we,
    input  wire  [1:0]         i_cfg_index,
    input  wire  [15:0]        i_cfg_data,
    // input beats
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire  [1:0]         i_command,
    input  wire  [7:0]         i_byte_value,
    input  wire  [7:0]         i_table_index,
    input  wire  [15:0]        i_width_value,
    // result beats
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic [39:0]        o_text_width,
    output logic signed [31:0] o_text_height
);

    tem_pkg::t_dp_cmd  w_cmd;
    tem_pkg::t_dp_stat w_stat;

    tem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    tem_datapath #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .FIRST_CODE  (FIRST_CODE)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_command     (i_command),
        .i_byte_value  (i_byte_value),
        .i_table_index (i_table_index),
        .i_width_value (i_width_value),
        .o_text_width  (o_text_width),
        .o_text_height (o_text_height)
    );

endmodule

`default_nettype wire

// ===== rtl/tem_datapath.sv =====
`default_nettype none

module tem_datapath #(
    parameter int GLYPH_COUNT = 224,
    parameter int FIRST_CODE  = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  tem_pkg::t_dp_cmd       i_cmd,
    output tem_pkg::t_dp_stat      o_stat,
    input  wire                    i_cfg_we,
    input  wire  [1:0]             i_cfg_index,
    input  wire  [15:0]            i_cfg_data,
    input  wire  [1:0]             i_command,
    input  wire  [7:0]             i_byte_value,
    input  wire  [7:0]             i_table_index,
    input  wire  [15:0]            i_width_value,
    output logic [39:0]            o_text_width,
    output logic signed [31:0]     o_text_height
);

    localparam int ADDR_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

    // Captured beat
    tem_pkg::t_command  r_command;
    logic [7:0]         r_byte;
    logic [7:0]         r_tbl_index;
    logic [15:0]        r_width_value;

    // Configuration
    logic signed [15:0] r_scale_x;
    logic signed [15:0] r_scale_y;
    logic               r_stop_mode;

    // Width table
    logic [15:0]        r_table [GLYPH_COUNT];
    logic [15:0]        r_rdata;

    // Measurement state
    logic [7:0]         r_held [tem_pkg::HELD_MAX];
    logic [3:0]         r_held_count;
    logic [3:0]         r_flush_idx;
    logic               r_stopped;
    logic signed [32:0] r_prod;
    logic signed [40:0] r_pen_x;
    logic [39:0]        r_widest;
    logic signed [31:0] r_pen_y;

    // Result
    logic [39:0]        r_text_width;
    logic signed [31:0] r_text_height;

    logic [7:0]         w_glyph_byte;
    logic [8:0]         w_diff;
    logic               w_in_range;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic               w_wr_ok;
    logic signed [16:0] w_width_s;
    logic signed [32:0] w_prod;
    logic signed [41:0] w_pen_sum;
    logic signed [40:0] n_pen_x;
    logic signed [32:0] w_pen_y_sum;
    logic signed [31:0] n_pen_y;
    logic [40:0]        w_neg_x;
    logic [40:0]        w_mag;
    logic [39:0]        w_abs_x;
    logic [39:0]        w_line_max;
    logic [3:0]         w_push_count;
    logic [3:0]         w_need;
    logic [3:0]         n_held_count;

    // Glyph index: out-of-range bytes fall back to entry 0
    assign w_glyph_byte = i_cmd.sel_held ? r_held[r_flush_idx] : r_byte;
    assign w_diff       = {1'b0, w_glyph_byte} - 9'(FIRST_CODE);
    assign w_in_range   = (w_glyph_byte >= 8'(FIRST_CODE)) && (w_diff < 9'(GLYPH_COUNT));
    assign w_rd_addr    = w_in_range ? w_diff[ADDR_W-1:0] : '0;
    assign w_wr_ok      = ({1'b0, r_tbl_index} < 9'(GLYPH_COUNT));

    // Table memory, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.tbl_write && w_wr_ok) begin
            r_table[r_tbl_index[ADDR_W-1:0]] <= r_width_value;
        end
        r_rdata <= r_table[w_rd_addr];
    end

    // Width times scale, exact Q.8 (scale_x is Q8.8)
    assign w_width_s = signed'({1'b0, r_rdata});
    assign w_prod    = w_width_s * r_scale_x;

    // Saturating pen x accumulate
    assign w_pen_sum = 42'(r_pen_x) + 42'(r_prod);
    always_comb begin
        if (w_pen_sum[41] != w_pen_sum[40]) begin
            n_pen_x = w_pen_sum[41] ? {1'b1, 40'd0} : {1'b0, {40{1'b1}}};
        end else begin
            n_pen_x = w_pen_sum[40:0];
        end
    end

    // Saturating pen y step
    assign w_pen_y_sum = 33'(r_pen_y) + 33'(r_scale_y);
    always_comb begin
        if (w_pen_y_sum[32] != w_pen_y_sum[31]) begin
            n_pen_y = w_pen_y_sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            n_pen_y = w_pen_y_sum[31:0];
        end
    end

    // Absolute line width, saturated to 40 bits, and the running max
    assign w_neg_x    = ~r_pen_x + 41'd1;
    assign w_mag      = r_pen_x[40] ? w_neg_x : r_pen_x;
    assign w_abs_x    = w_mag[40] ? {40{1'b1}} : w_mag[39:0];
    assign w_line_max = (w_abs_x > r_widest) ? w_abs_x : r_widest;

    // Held count after a push; a complete escape empties the buffer
    assign w_push_count = r_held_count + 4'd1;
    assign w_need       = (r_held[1] == tem_pkg::CH_PCT) ? tem_pkg::NEED_PCT
                                                         : tem_pkg::NEED_HASH;
    always_comb begin
        n_held_count = w_push_count;
        if ((r_held_count >= tem_pkg::ESC_LEAD_LEN) && (w_push_count >= w_need)) begin
            n_held_count = '0;
        end
    end

    // Control and measurement registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_x    <= tem_pkg::SCALE_RESET;
            r_scale_y    <= tem_pkg::SCALE_RESET;
            r_stop_mode  <= 1'b0;
            r_held_count <= '0;
            r_flush_idx  <= '0;
            r_stopped    <= 1'b0;
            r_pen_x      <= '0;
            r_widest     <= '0;
            r_pen_y      <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tem_pkg::CFG_SCALE_X: r_scale_x   <= i_cfg_data;
                    tem_pkg::CFG_SCALE_Y: r_scale_y   <= i_cfg_data;
                    tem_pkg::CFG_STOP:    r_stop_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.glyph_acc) begin
                r_pen_x <= n_pen_x;
            end
            if (i_cmd.newline) begin
                r_pen_y  <= n_pen_y;
                r_widest <= w_line_max;
                r_pen_x  <= '0;
            end
            if (i_cmd.set_stop) begin
                r_stopped <= 1'b1;
            end
            if (i_cmd.push) begin
                r_held_count <= n_held_count;
            end
            if (i_cmd.flush_start) begin
                r_flush_idx <= '0;
            end else if (i_cmd.flush_next) begin
                r_flush_idx <= r_flush_idx + 4'd1;
            end
            if (i_cmd.flush_end) begin
                r_held_count <= '0;
            end
            if (i_cmd.out_load) begin
                r_pen_x      <= '0;
                r_widest     <= '0;
                r_pen_y      <= '0;
                r_held_count <= '0;
                r_stopped    <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_command     <= tem_pkg::t_command'(i_command);
            r_byte        <= i_byte_value;
            r_tbl_index   <= i_table_index;
            r_width_value <= i_width_value;
        end
        if (i_cmd.glyph_mul) begin
            r_prod <= w_prod;
        end
        if (i_cmd.push) begin
            r_held[r_held_count] <= r_byte;
        end
        if (i_cmd.out_load) begin
            r_text_width  <= w_line_max;
            r_text_height <= r_pen_y;
        end
    end

    // Status to the controller
    always_comb begin
        o_stat.command    = r_command;
        o_stat.is_nl      = (r_byte == tem_pkg::CH_NL);
        o_stat.is_bsl     = (r_byte == tem_pkg::CH_BSL);
        o_stat.is_lead    = (r_byte == tem_pkg::CH_HASH) || (r_byte == tem_pkg::CH_PCT);
        o_stat.is_hex     = ((r_byte >= 8'h30) && (r_byte <= 8'h39))
                         || ((r_byte >= 8'h41) && (r_byte <= 8'h46))
                         || ((r_byte >= 8'h61) && (r_byte <= 8'h66));
        o_stat.held_zero  = (r_held_count == 4'd0);
        o_stat.held_one   = (r_held_count == 4'd1);
        o_stat.held_mid   = (r_held_count >= tem_pkg::ESC_LEAD_LEN)
                         && (r_held_count < 4'(tem_pkg::HELD_MAX));
        o_stat.stopped    = r_stopped;
        o_stat.stop_mode  = r_stop_mode;
        o_stat.flush_last = ((r_flush_idx + 4'd1) == r_held_count);
    end

    assign o_text_width  = r_text_width;
    assign o_text_height = r_text_height;

`ifndef SYNTH
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_count < 4'(tem_pkg::HELD_MAX))
        else $error("held count beyond buffer");

    a_stop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |-> (r_held_count == 4'd0))
        else $error("escape held while stopped");

    a_out_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> (r_pen_x == '0) && (r_pen_y == '0) && (r_held_count == 4'd0))
        else $error("measurement not cleared after result");
`endif

endmodule

`default_nettype wire

// ===== rtl/tem_ctrl.sv =====
`default_nettype none

module tem_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    input  tem_pkg::t_dp_stat  i_stat,
    output tem_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RD,
        S_MUL,
        S_ACC,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_flushing;
    logic   n_flushing;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    // Next state and datapath commands
    always_comb begin
        n_state     = r_state;
        n_flushing  = r_flushing;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.in_load = w_accept;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_DECODE;
                end
            end

            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_stat.command)
                    tem_pkg::CMD_LOAD: begin
                        o_cmd.tbl_write = 1'b1;
                    end
                    tem_pkg::CMD_BYTE: begin
                        if (i_stat.stopped) begin
                            n_state = S_IDLE;
                        end else if (i_stat.held_zero) begin
                            // plain scan
                            if (i_stat.is_nl) begin
                                if (i_stat.stop_mode) begin
                                    o_cmd.set_stop = 1'b1;
                                end else begin
                                    o_cmd.newline = 1'b1;
                                end
                            end else if (i_stat.is_bsl) begin
                                o_cmd.push = 1'b1;
                            end else begin
                                n_state = S_MUL;
                            end
                        end else if (i_stat.held_one && i_stat.is_lead) begin
                            o_cmd.push = 1'b1;
                        end else if (i_stat.held_mid && i_stat.is_hex) begin
                            o_cmd.push = 1'b1;
                        end else begin
                            // broken escape: held bytes become glyphs, then rescan
                            o_cmd.flush_start = 1'b1;
                            n_flushing = 1'b1;
                            n_state    = S_RD;
                        end
                    end
                    tem_pkg::CMD_END: begin
                        if (!i_stat.stopped && !i_stat.held_zero) begin
                            o_cmd.flush_start = 1'b1;
                            n_flushing = 1'b1;
                            n_state    = S_RD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                    default: ;
                endcase
            end

            S_RD: begin
                o_cmd.sel_held = 1'b1;
                n_state = S_MUL;
            end

            S_MUL: begin
                o_cmd.glyph_mul = 1'b1;
                n_state = S_ACC;
            end

            S_ACC: begin
                o_cmd.glyph_acc = 1'b1;
                if (r_flushing) begin
                    if (i_stat.flush_last) begin
                        o_cmd.flush_end = 1'b1;
                        n_flushing = 1'b0;
                        n_state    = S_DECODE;
                    end else begin
                        o_cmd.flush_next = 1'b1;
                        n_state = S_RD;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end

            S_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_flushing  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_flushing  <= n_flushing;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTH
    a_flush_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flushing |-> (r_state == S_RD) || (r_state == S_MUL) || (r_state == S_ACC))
        else $error("flush flag outside glyph states");

    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_DECODE))
        else $error("accepted beat not decoded");

    a_out_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && r_out_valid && !i_out_ready) |=> (r_state == S_OUT))
        else $error("result overwrote a pending beat");
`endif

endmodule

`default_nettype wire
